// ===== src/rpn_pkg.sv =====
// Shared constants, types and codes of the postfix pixel evaluator.
`timescale 1ns / 1ps
`default_nettype none

package rpn_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_BITS   = 16;
    localparam int STACK_DEPTH = 16;
    localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int PROD_W      = 2 * DATA_W;
    localparam int QUO_W       = DATA_W + FRAC_BITS;
    localparam int STEP_W      = $clog2(QUO_W + 1);

    localparam logic [DATA_W-1:0] FX_ONE = DATA_W'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        ACT_PUSH   = 3'd0,
        ACT_ADD    = 3'd1,
        ACT_SUB    = 3'd2,
        ACT_MUL    = 3'd3,
        ACT_DIV    = 3'd4,
        ACT_INVERT = 3'd5,
        ACT_MTF    = 3'd6,
        ACT_NONE   = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_EMPTY = 2'd2,
        ST_OVER  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_END,
        S_EMIT
    } state_t;

    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL,
        A_MUL_OUT,
        A_MTF_NUM,
        A_MTF_DEN,
        A_MTF_SUM,
        A_DIV,
        A_DIV_OUT
    } alu_state_t;

    typedef struct packed {
        logic                     start;
        action_t                  op;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] result;
    } alu_rsp_t;

endpackage

`default_nettype wire

// ===== src/rpn_if.sv =====
// Token and result channel interfaces of the postfix pixel evaluator.
`timescale 1ns / 1ps
`default_nettype none

interface rpn_tok_if
    import rpn_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [2:0]               action;
    logic signed [DATA_W-1:0] operand_value;
    logic                     last_token;

    modport source (output valid, output action, output operand_value, output last_token,
                    input ready);
    modport sink   (input valid, input action, input operand_value, input last_token,
                    output ready);
endinterface

interface rpn_res_if
    import rpn_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] pixel_result;
    logic [1:0]               status;

    modport source (output valid, output pixel_result, output status, input ready);
    modport sink   (input valid, input pixel_result, input status, output ready);
endinterface

`default_nettype wire

// ===== src/rpn_ram.sv =====
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr_a,
    output logic      [WIDTH-1:0] rdata_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_a_reg <= mem_reg[raddr_a];
        rd_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

`default_nettype wire

// ===== src/rpn_alu.sv =====
// Shared multiply and restoring-divide unit for multiply, divide and MTF.
`timescale 1ns / 1ps
`default_nettype none

module rpn_alu
    import rpn_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire alu_req_t req,
    output alu_rsp_t      rsp
);

    alu_state_t               state_reg, state_next;
    logic [DATA_W-1:0]        opa_reg, opa_next;
    logic [DATA_W-1:0]        opb_reg, opb_next;
    logic                     neg_reg, neg_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [PROD_W-1:0]        rem_reg, rem_next;
    logic [PROD_W-1:0]        den_reg, den_next;
    logic [DATA_W-1:0]        dvd_reg, dvd_next;
    logic [QUO_W-1:0]         quo_reg, quo_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic signed [DATA_W-1:0] res_reg, res_next;
    logic                     done_reg, done_next;

    logic [PROD_W-1:0]        mult;
    logic [PROD_W:0]          rem_shift;
    logic                     rem_fits;
    logic [DATA_W-1:0]        mag_a;
    logic [DATA_W-1:0]        mag_b;

    function automatic logic signed [DATA_W-1:0] sat_mag(input logic neg,
                                                         input logic [PROD_W-1:0] mag);
        logic big;
        begin
            big = |mag[PROD_W-1:DATA_W-1];
            if (neg)
            begin
                sat_mag = big ? {1'b1, {(DATA_W-1){1'b0}}} : -$signed(mag[DATA_W-1:0]);
            end
            else
            begin
                sat_mag = big ? {1'b0, {(DATA_W-1){1'b1}}} : $signed(mag[DATA_W-1:0]);
            end
        end
    endfunction

    assign mult      = PROD_W'(opa_reg) * PROD_W'(opb_reg);
    assign rem_shift = {rem_reg, dvd_reg[DATA_W-1]};
    assign rem_fits  = rem_shift >= {1'b0, den_reg};
    assign mag_a     = req.a[DATA_W-1] ? DATA_W'(-req.a) : DATA_W'(req.a);
    assign mag_b     = req.b[DATA_W-1] ? DATA_W'(-req.b) : DATA_W'(req.b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg  <= opa_next;
        opb_reg  <= opb_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        dvd_reg  <= dvd_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        opa_next   = opa_reg;
        opb_next   = opb_reg;
        neg_next   = neg_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        res_next   = res_reg;
        done_next  = 1'b0;

        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    unique case (req.op)
                        ACT_MUL:
                        begin
                            opa_next   = mag_a;
                            opb_next   = mag_b;
                            neg_next   = req.a[DATA_W-1] ^ req.b[DATA_W-1];
                            state_next = A_MUL;
                        end
                        ACT_DIV:
                        begin
                            if (req.b == '0)
                            begin
                                res_next  = '0;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                den_next   = PROD_W'(mag_b);
                                rem_next   = '0;
                                dvd_next   = mag_a;
                                quo_next   = '0;
                                neg_next   = req.a[DATA_W-1] ^ req.b[DATA_W-1];
                                step_next  = STEP_W'(QUO_W);
                                state_next = A_DIV;
                            end
                        end
                        default:
                        begin
                            if (req.b[DATA_W-1] || req.b == '0)
                            begin
                                res_next  = '0;
                                done_next = 1'b1;
                            end
                            else if (req.b >= $signed(FX_ONE))
                            begin
                                res_next  = $signed(FX_ONE);
                                done_next = 1'b1;
                            end
                            else if (req.a[DATA_W-1] || req.a == '0 ||
                                     req.a >= $signed(FX_ONE))
                            begin
                                res_next  = req.b;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                opa_next   = FX_ONE - DATA_W'(req.a);
                                opb_next   = DATA_W'(req.b);
                                state_next = A_MTF_NUM;
                            end
                        end
                    endcase
                end
            end
            A_MUL:
            begin
                prod_next  = mult;
                state_next = A_MUL_OUT;
            end
            A_MUL_OUT:
            begin
                res_next   = sat_mag(neg_reg, prod_reg >> FRAC_BITS);
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            A_MTF_NUM:
            begin
                prod_next  = mult;
                opa_next   = FX_ONE - opa_reg;
                opb_next   = FX_ONE - opb_reg;
                state_next = A_MTF_DEN;
            end
            A_MTF_DEN:
            begin
                rem_next   = prod_reg;
                prod_next  = mult;
                state_next = A_MTF_SUM;
            end
            A_MTF_SUM:
            begin
                den_next   = prod_reg + rem_reg;
                dvd_next   = '0;
                quo_next   = '0;
                neg_next   = 1'b0;
                step_next  = STEP_W'(FRAC_BITS);
                state_next = A_DIV;
            end
            A_DIV:
            begin
                rem_next  = rem_fits ? PROD_W'(rem_shift - {1'b0, den_reg})
                                     : PROD_W'(rem_shift);
                quo_next  = {quo_reg[QUO_W-2:0], rem_fits};
                dvd_next  = {dvd_reg[DATA_W-2:0], 1'b0};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    state_next = A_DIV_OUT;
                end
            end
            A_DIV_OUT:
            begin
                res_next   = sat_mag(neg_reg, PROD_W'(quo_reg));
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

`default_nettype wire

// ===== src/pixel_rpn_stack_evaluator.sv =====
// Top level of the postfix pixel evaluator: token sequencer, stack and result register.
//
// Usage: tokens arrive on the token channel (valid/ready) as action, operand_value and
// last_token. A push places operand_value on a 16-entry stack; operators pop their
// operands and push one result. On the token marked last, one transaction leaves on the
// result channel with pixel_result (top of stack, or 0) and status (ok, underflow,
// empty, overflow), and the stack and fault latch clear for the next pixel.
// The block takes one token at a time and drops ready while it works on it.
// Push, add, subtract, invert and ignored tokens work on the stack alone; multiply makes
// one pass through the shared multiplier; divide runs the shared restoring divider, one
// quotient bit a cycle over 48 bits (skipped for a zero divisor); mtf makes two passes
// through the shared multiplier and 16 divider steps (skipped when x or mid lies at an
// end case). A last token then loads the result register from the top of stack.
// The result register holds the transaction while the receiver stalls; new tokens
// are still taken then, and only the next last token waits for the register to free.
// Reset (rst_n low, asynchronous) empties the stack, clears the fault latch and the
// result valid flag and holds ready low; no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none

module pixel_rpn_stack_evaluator
    import rpn_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rpn_tok_if.sink   token,
    rpn_res_if.source result
);

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    status_t                  fault_reg, fault_next;
    action_t                  act_reg;
    logic signed [DATA_W-1:0] opnd_reg;
    logic                     last_reg;

    logic                     res_valid_reg, res_valid_next;
    logic signed [DATA_W-1:0] res_data_reg, res_data_next;
    status_t                  res_status_reg, res_status_next;

    logic                     tok_take;
    logic                     ram_we;
    logic [PTR_W-1:0]         ram_waddr;
    logic signed [DATA_W-1:0] ram_wdata;
    logic [PTR_W-1:0]         addr_top;
    logic [PTR_W-1:0]         addr_next;
    logic [DATA_W-1:0]        rd_top;
    logic [DATA_W-1:0]        rd_next;
    logic signed [DATA_W:0]   top_ext;
    logic signed [DATA_W:0]   next_ext;
    logic signed [DATA_W:0]   one_ext;

    alu_req_t                 alu_req;
    alu_rsp_t                 alu_rsp;

    function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [DATA_W:0] s);
        begin
            if (s[DATA_W] != s[DATA_W-1])
            begin
                sat_sum = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                    : {1'b0, {(DATA_W-1){1'b1}}};
            end
            else
            begin
                sat_sum = s[DATA_W-1:0];
            end
        end
    endfunction

    assign addr_top  = PTR_W'(count_reg - CNT_W'(1));
    assign addr_next = PTR_W'(count_reg - CNT_W'(2));
    assign top_ext   = $signed({rd_top[DATA_W-1], rd_top});
    assign next_ext  = $signed({rd_next[DATA_W-1], rd_next});
    assign one_ext   = $signed({1'b0, FX_ONE});

    rpn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (addr_top),
        .rdata_a (rd_top),
        .raddr_b (addr_next),
        .rdata_b (rd_next)
    );

    rpn_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    assign token.ready = rst_n && (state_reg == S_IDLE);
    assign tok_take    = token.valid && token.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            fault_reg     <= ST_OK;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            fault_reg     <= fault_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_take)
        begin
            act_reg  <= action_t'(token.action);
            opnd_reg <= token.operand_value;
            last_reg <= token.last_token;
        end
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        fault_next      = fault_reg;
        ram_we          = 1'b0;
        ram_waddr       = addr_next;
        ram_wdata       = sat_sum(next_ext + top_ext);
        alu_req.start   = 1'b0;
        alu_req.op      = act_reg;
        alu_req.a       = $signed(rd_next);
        alu_req.b       = $signed(rd_top);
        res_valid_next  = res_valid_reg && !result.ready;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (tok_take)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_END;
                if (fault_reg == ST_OK)
                begin
                    unique case (act_reg) inside
                        ACT_PUSH:
                        begin
                            if (count_reg >= CNT_W'(STACK_DEPTH))
                            begin
                                fault_next = ST_OVER;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[PTR_W-1:0];
                                ram_wdata  = opnd_reg;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_INVERT:
                        begin
                            if (count_reg == '0)
                            begin
                                fault_next = ST_UNDER;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = addr_top;
                                ram_wdata = sat_sum(one_ext - top_ext);
                            end
                        end
                        ACT_ADD, ACT_SUB:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                fault_next = ST_UNDER;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_wdata  = (act_reg == ACT_ADD) ? sat_sum(next_ext + top_ext)
                                                                  : sat_sum(next_ext - top_ext);
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        ACT_MUL, ACT_DIV, ACT_MTF:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                fault_next = ST_UNDER;
                            end
                            else
                            begin
                                alu_req.start = 1'b1;
                                state_next    = S_WAIT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = alu_rsp.result;
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_END;
                end
            end
            S_END:
            begin
                state_next = last_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next = 1'b1;
                    if (fault_reg != ST_OK)
                    begin
                        res_data_next   = '0;
                        res_status_next = fault_reg;
                    end
                    else if (count_reg == '0)
                    begin
                        res_data_next   = '0;
                        res_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        res_data_next   = $signed(rd_top);
                        res_status_next = ST_OK;
                    end
                    count_next = '0;
                    fault_next = ST_OK;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign result.valid        = res_valid_reg;
    assign result.pixel_result = res_data_reg;
    assign result.status       = res_status_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (fault_reg == ST_OK && (state_reg == S_EXEC || state_reg == S_WAIT)))
    else $error("stack write outside execution or with a latched fault");

    assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> state_reg == S_WAIT)
    else $error("arithmetic unit finished with no operation waiting");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && state_next == S_IDLE) |=>
            (count_reg == '0 && fault_reg == ST_OK && res_valid_reg))
    else $error("evaluator not cleared after emitting a result");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for the postfix pixel evaluator: token stimulus, stack predictor and result checks.
`timescale 1ns / 1ps

module tb;
    import rpn_pkg::*;

    localparam int     STALL_LIMIT   = 4000;
    localparam int     SETTLE_CYCLES = 64;
    localparam longint Q_ONE         = longint'(FX_ONE);

    typedef struct {
        action_t                  act;
        logic signed [DATA_W-1:0] val;
    } rpn_token_t;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        status_t                  code;
    } pixel_out_t;

    logic clk;
    logic rst_n;

    rpn_tok_if tok_bus ();
    rpn_res_if res_bus ();

    pixel_rpn_stack_evaluator u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .token  (tok_bus),
        .result (res_bus)
    );

    logic signed [DATA_W-1:0] eval_stack [STACK_DEPTH];
    int                       eval_depth;
    status_t                  eval_fault;
    pixel_out_t               pending_pixels [$];
    pixel_out_t               want;

    int errors;
    int tokens_sent;
    int results_checked;
    int burst_left;
    int hold_off;
    int quiet_cycles;
    int status_seen [4];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic signed [DATA_W-1:0] clamp_q16(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_signed_mag(input bit neg,
                                                                 input longint unsigned mag);
        longint t;
        if (neg)
        begin
            if (mag >= 64'h8000_0000)
                return 32'sh8000_0000;
            t = -longint'(mag);
            return t[DATA_W-1:0];
        end
        if (mag > 64'h7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        return mag[DATA_W-1:0];
    endfunction

    function automatic longint unsigned abs_wide(input logic signed [DATA_W-1:0] v);
        longint t;
        t = v;
        return (t < 0) ? -t : t;
    endfunction

    function automatic logic signed [DATA_W-1:0] q16_mul(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
        return clamp_signed_mag((a < 0) != (b < 0), (abs_wide(a) * abs_wide(b)) >> FRAC_BITS);
    endfunction

    function automatic logic signed [DATA_W-1:0] q16_div(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
        if (b == 0)
            return '0;
        return clamp_signed_mag((a < 0) != (b < 0), (abs_wide(a) << FRAC_BITS) / abs_wide(b));
    endfunction

    function automatic logic signed [DATA_W-1:0] q16_mtf(input logic signed [DATA_W-1:0] m,
                                                        input logic signed [DATA_W-1:0] x);
        longint          xw;
        longint          mw;
        longint unsigned num;
        longint unsigned den;
        longint unsigned rem;
        longint unsigned quo;
        xw = x;
        mw = m;
        if (xw <= 0)
            return '0;
        if (xw >= Q_ONE)
            return FX_ONE;
        if (mw <= 0 || mw >= Q_ONE)
            return x;
        num = (Q_ONE - mw) * xw;
        den = mw * (Q_ONE - xw) + xw * (Q_ONE - mw);
        rem = num;
        quo = 0;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo[DATA_W-1:0];
    endfunction

    function automatic void evaluate_token(input action_t act,
                                           input logic signed [DATA_W-1:0] val,
                                           input bit last);
        logic signed [DATA_W-1:0] lhs;
        logic signed [DATA_W-1:0] rhs;
        logic signed [DATA_W-1:0] res;
        pixel_out_t               pix;
        if (eval_fault == ST_OK && act != ACT_NONE)
        begin
            case (act)
                ACT_PUSH:
                begin
                    if (eval_depth >= STACK_DEPTH)
                        eval_fault = ST_OVER;
                    else
                    begin
                        eval_stack[eval_depth] = val;
                        eval_depth++;
                    end
                end
                ACT_INVERT:
                begin
                    if (eval_depth < 1)
                        eval_fault = ST_UNDER;
                    else
                        eval_stack[eval_depth-1] =
                            clamp_q16(Q_ONE - longint'(eval_stack[eval_depth-1]));
                end
                default:
                begin
                    if (eval_depth < 2)
                        eval_fault = ST_UNDER;
                    else
                    begin
                        rhs = eval_stack[eval_depth-1];
                        lhs = eval_stack[eval_depth-2];
                        case (act)
                            ACT_ADD: res = clamp_q16(longint'(lhs) + longint'(rhs));
                            ACT_SUB: res = clamp_q16(longint'(lhs) - longint'(rhs));
                            ACT_MUL: res = q16_mul(lhs, rhs);
                            ACT_DIV: res = q16_div(lhs, rhs);
                            default: res = q16_mtf(lhs, rhs);
                        endcase
                        eval_depth--;
                        eval_stack[eval_depth-1] = res;
                    end
                end
            endcase
        end
        if (last)
        begin
            pix.value = '0;
            if (eval_fault != ST_OK)
                pix.code = eval_fault;
            else if (eval_depth == 0)
                pix.code = ST_EMPTY;
            else
            begin
                pix.code  = ST_OK;
                pix.value = eval_stack[eval_depth-1];
            end
            pending_pixels = {pending_pixels, pix};
            eval_depth = 0;
            eval_fault = ST_OK;
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_operand();
        logic signed [DATA_W-1:0] t;
        case ($urandom_range(0, 9)) inside
            [0:3]: return $urandom_range(0, FX_ONE);
            4:
            begin
                case ($urandom_range(0, 5))
                    0: return '0;
                    1: return FX_ONE;
                    2: return -$signed(FX_ONE);
                    3: return 32'sh7FFF_FFFF;
                    4: return 32'sh8000_0000;
                    default: return 32'sd1;
                endcase
            end
            5:
            begin
                t = $urandom_range(0, 32) << FRAC_BITS;
                if ($urandom_range(0, 1) == 1)
                    t = -t;
                return t;
            end
            6: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_token(input action_t act, input logic signed [DATA_W-1:0] val,
                              input bit last);
        int gap;
        bit took;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                tok_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        tok_bus.valid         <= 1'b1;
        tok_bus.action        <= act;
        tok_bus.operand_value <= val;
        tok_bus.last_token    <= last;
        do
        begin
            @(negedge clk);
            took = tok_bus.ready;
            @(posedge clk);
        end
        while (!took);
        evaluate_token(act, val, last);
        tokens_sent++;
    endtask

    task automatic send_sequence(input rpn_token_t seq [$]);
        foreach (seq[k])
            send_token(seq[k].act, seq[k].val, k == seq.size() - 1);
    endtask

    task automatic wait_for_results();
        tok_bus.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending_pixels.size() != 0);
    endtask

    task automatic send_expression(input int len);
        rpn_token_t seq [$];
        rpn_token_t t;
        int         depth;
        depth = 0;
        repeat (len)
        begin
            t.val = pick_operand();
            if (depth == 0 || (depth < STACK_DEPTH && $urandom_range(0, 1) == 1))
            begin
                t.act = ACT_PUSH;
                depth++;
            end
            else if (depth == 1)
                t.act = ACT_INVERT;
            else
            begin
                t.act = action_t'($urandom_range(ACT_ADD, ACT_MTF));
                if (t.act != ACT_INVERT)
                    depth--;
            end
            seq = {seq, t};
        end
        send_sequence(seq);
    endtask

    task automatic test_operators();
        send_token(ACT_PUSH, 32'sh0000_4000, 1'b0);
        send_token(ACT_PUSH, 32'sh0000_8000, 1'b0);
        send_token(ACT_MTF, '0, 1'b0);
        send_token(ACT_PUSH, 32'sh8000_0000, 1'b0);
        send_token(ACT_SUB, '0, 1'b0);
        send_token(ACT_PUSH, '0, 1'b0);
        send_token(ACT_DIV, '0, 1'b0);
        send_token(ACT_INVERT, '0, 1'b0);
        send_token(ACT_PUSH, 32'sh7FFF_FFFF, 1'b0);
        send_token(ACT_MUL, '0, 1'b0);
        send_token(ACT_PUSH, 32'sh7FFF_FFFF, 1'b0);
        send_token(ACT_ADD, 32'shFFFF_FFFF, 1'b1);
    endtask

    task automatic test_overflow();
        for (int i = 0; i <= STACK_DEPTH; i++)
            send_token(ACT_PUSH, (i % 2 == 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFF,
                       i == STACK_DEPTH);
    endtask

    task automatic test_underflow_and_empty();
        send_token(ACT_SUB, '0, 1'b0);
        send_token(ACT_PUSH, FX_ONE, 1'b1);
        send_token(ACT_NONE, '0, 1'b1);
    endtask

    task automatic test_well_formed(input int count);
        int start;
        start = tokens_sent;
        while (tokens_sent - start < count)
            send_expression(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                        : $urandom_range(1, 12));
    endtask

    task automatic test_result_backpressure();
        hold_off = 400;
        repeat (10)
            send_expression($urandom_range(1, 4));
        wait_for_results();
    endtask

    task automatic test_broken_sequences(input int count);
        rpn_token_t seq [$];
        rpn_token_t t;
        int         start;
        start = tokens_sent;
        while (tokens_sent - start < count)
        begin
            seq.delete();
            if ($urandom_range(0, 3) == 0)
            begin
                repeat (STACK_DEPTH + $urandom_range(1, 3))
                begin
                    t.act = ACT_PUSH;
                    t.val = pick_operand();
                    seq = {seq, t};
                end
            end
            repeat ($urandom_range(1, 12))
            begin
                t.act = action_t'($urandom_range(0, 7));
                t.val = pick_operand();
                seq = {seq, t};
            end
            send_sequence(seq);
        end
    endtask

    initial
    begin
        int mode;
        int span;
        mode = 0;
        span = 0;
        res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                res_bus.ready <= 1'b0;
                hold_off--;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(20, 200);
                end
                span--;
                case (mode)
                    0: res_bus.ready <= 1'b1;
                    1: res_bus.ready <= $urandom_range(0, 1);
                    2: res_bus.ready <= ($urandom_range(0, 3) == 0);
                    default: res_bus.ready <= (span % 7 < 4);
                endcase
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                errors++;
                if (errors < 50)
                    $display("%0t: unexpected result transaction: pixel_result %h status %0d",
                             $time, res_bus.pixel_result, res_bus.status);
            end
            else
            begin
                want = pending_pixels.pop_front();
                results_checked++;
                status_seen[want.code]++;
                if (res_bus.pixel_result !== want.value)
                begin
                    errors++;
                    if (errors < 50)
                        $display("%0t: pixel_result expected %h actual %h", $time,
                                 want.value, res_bus.pixel_result);
                end
                if (res_bus.status !== want.code)
                begin
                    errors++;
                    if (errors < 50)
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.code, res_bus.status);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || (tok_bus.valid && tok_bus.ready) || (res_bus.valid && res_bus.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("tb: errors");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n                 <= 1'b0;
        tok_bus.valid         <= 1'b0;
        tok_bus.action        <= ACT_NONE;
        tok_bus.operand_value <= '0;
        tok_bus.last_token    <= 1'b0;
        eval_fault = ST_OK;
        eval_depth = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_operators();
        test_overflow();
        test_underflow_and_empty();
        wait_for_results();
        test_well_formed(800);
        test_result_backpressure();
        test_broken_sequences(400);
        wait_for_results();
        test_well_formed(800);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("tb: %0d tokens in, %0d pixel results checked", tokens_sent, results_checked);
        $display("tb: status ok %0d, underflow %0d, empty %0d, overflow %0d",
                 status_seen[ST_OK], status_seen[ST_UNDER], status_seen[ST_EMPTY],
                 status_seen[ST_OVER]);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
